@@ hw/rtl/rdlc_pkg.sv @@
`default_nettype none

package rdlc_pkg;

   // request opcodes
   localparam logic [1:0] OP_WEIGHT = 2'd0;
   localparam logic [1:0] OP_MEMORY = 2'd1;
   localparam logic [1:0] OP_RUN    = 2'd2;

   // fixed-point format, q3.12
   localparam int FRAC_BITS = 12;
   localparam int Q_ONE     = 4096;

   // field widths
   localparam int OP_W    = 2;
   localparam int ROW_W   = 3;
   localparam int COL_W   = 3;
   localparam int VAL_W   = 16;
   localparam int SENSE_W = 14;
   localparam int ACCEL_W = 17;
   localparam int TURN_W  = 14;
   localparam int REQ_TDATA_W = 56;
   localparam int RSP_TDATA_W = 32;

   // source of the x operand for one column
   typedef enum logic [2:0] {
      XS_ZERO,
      XS_SPEED,
      XS_ANGLE,
      XS_ONE,
      XS_MEM
   } xsel_type;

   // sequencer jump conditions
   typedef enum logic [2:0] {
      JC_NEXT,
      JC_ALWAYS,
      JC_COL_MORE,
      JC_ROW_MORE,
      JC_MEM_MORE
   } jump_type;

   typedef logic [2:0] upc_type;

   localparam upc_type UP_IDLE   = 3'd0;
   localparam upc_type UP_ISSUE  = 3'd1;
   localparam upc_type UP_DRAIN0 = 3'd2;
   localparam upc_type UP_DRAIN1 = 3'd3;
   localparam upc_type UP_ROWEND = 3'd4;
   localparam upc_type UP_MEMRD  = 3'd5;
   localparam upc_type UP_MEMWR  = 3'd6;
   localparam upc_type UP_OUT    = 3'd7;

   localparam int UCODE_DEPTH = 8;

   typedef struct packed {
      logic     issue;       // read one weight and one x operand
      logic     row_end;     // clamp accumulator, store row result
      logic     mem_rd;      // read memory value and row result
      logic     mem_wr;      // write back leaky memory update
      logic     out_load;    // load the response register
      logic     wait_start;  // hold until a run transaction arrives
      logic     wait_out;    // hold while the response is not taken
      jump_type jc;
      upc_type  target;
   } ucode_word_type;

   // control program, one word per step
   localparam ucode_word_type UCODE_ROM [UCODE_DEPTH] = '{
      '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, JC_NEXT,     UP_IDLE},
      '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, JC_COL_MORE, UP_ISSUE},
      '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, JC_NEXT,     UP_IDLE},
      '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, JC_NEXT,     UP_IDLE},
      '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, JC_ROW_MORE, UP_ISSUE},
      '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, JC_NEXT,     UP_IDLE},
      '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, JC_MEM_MORE, UP_MEMRD},
      '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, JC_ALWAYS,   UP_IDLE}
   };

endpackage

`default_nettype wire

@@ hw/rtl/recurrent_dense_layer_clamp_top.sv @@
`default_nettype none
// a write is taken while the sequencer is idle; after a run is accepted it issues every
// column of each row, drains, stores the row result, updates each memory value and loads
// the response; no request is taken during a run, the next one the cycle after the load;
// a response still waiting for rsp_tready holds the sequencer
// reset: control and memory valid bits clear, so memory values read as zero; weights
// hold whatever was written and are undefined until then

module recurrent_dense_layer_clamp_top #(
   parameter int N_OUT = 6,
   parameter int N_IN  = 7,
   parameter int N_MEM = 4
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request channel
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // op[1:0], row[4:2], col[7:5], value[23:8], sense_speed[37:24], sense_angle[51:38]
   input  wire logic [rdlc_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // response channel
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // accel_out[16:0], turn_out[30:17]
   output logic [rdlc_pkg::RSP_TDATA_W-1:0]       rsp_tdata
);

   // sizes derived from the layer shape
   localparam int N_W   = N_OUT * N_IN;
   localparam int W_AW  = $clog2(N_W);
   localparam int RCW   = $clog2(N_OUT);
   localparam int CCW   = $clog2(N_IN);
   localparam int MIW   = (N_MEM > 1) ? $clog2(N_MEM) : 1;
   localparam int ACC_W = 32 + $clog2(N_IN);

   localparam logic signed [ACC_W-1:0] ACC_POS = ACC_W'(rdlc_pkg::Q_ONE);
   localparam logic signed [ACC_W-1:0] ACC_NEG = -ACC_POS;
   localparam logic signed [13:0]      Y_POS   = 14'(rdlc_pkg::Q_ONE);
   localparam logic signed [13:0]      Y_NEG   = -Y_POS;

   // request fields
   logic        [1:0]  req_op;
   logic        [2:0]  req_row;
   logic        [2:0]  req_col;
   logic signed [15:0] req_value;
   logic signed [13:0] req_speed;
   logic signed [13:0] req_angle;
   logic               req_acc;
   logic               start;

   assign req_op    = req_tdata[1:0];
   assign req_row   = req_tdata[4:2];
   assign req_col   = req_tdata[7:5];
   assign req_value = req_tdata[23:8];
   assign req_speed = req_tdata[37:24];
   assign req_angle = req_tdata[51:38];

   // sequencer
   rdlc_pkg::upc_type        pc_ff, pc_in;
   rdlc_pkg::ucode_word_type uw;
   logic                     out_busy;
   logic                     hold;
   logic                     jump;

   // counters
   logic [RCW-1:0]  row_cnt_ff, row_cnt_in;
   logic [CCW-1:0]  col_cnt_ff, col_cnt_in;
   logic [MIW-1:0]  mem_cnt_ff, mem_cnt_in;
   logic [W_AW-1:0] w_addr_ff, w_addr_in;
   logic            col_last, row_last, mem_last;

   // sensor values latched for the run
   logic signed [13:0] spd_ff, ang_ff;

   // storage
   logic signed [15:0] w_ram   [N_W];
   logic signed [15:0] mem_ram [N_MEM];
   logic signed [13:0] yb_ram  [N_MEM];
   logic [N_MEM-1:0]   mem_vld_ff;

   // datapath registers
   logic signed [15:0]     w_rd_ff;
   logic signed [15:0]     mem_rd_ff;
   logic                   mem_rvld_ff;
   logic signed [13:0]     yb_rd_ff;
   logic                   has_row_ff;
   logic                   rd_vld_ff;
   rdlc_pkg::xsel_type     xs_ff, xs_in;
   logic signed [31:0]     prod_ff;
   logic                   prod_vld_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic signed [13:0]     y0_ff, y1_ff;

   // response register
   logic                   rsp_tvalid_ff;
   logic signed [16:0]     rsp_accel_ff;
   logic signed [13:0]     rsp_turn_ff;

   // combinational datapath
   logic [MIW-1:0]          mem_raddr;
   logic [MIW-1:0]          col_maddr;
   logic [MIW-1:0]          mem_waddr;
   logic signed [15:0]      mem_wdata;
   logic                    mem_we;
   logic signed [15:0]      x_val;
   logic signed [ACC_W-1:0] acc_sh;
   logic signed [13:0]      y_clamp;
   logic signed [15:0]      m_cur;
   logic signed [13:0]      y_cur;
   logic signed [19:0]      m20;
   logic signed [19:0]      upd_sum;
   logic signed [15:0]      m_new;
   logic signed [16:0]      accel_val;
   logic                    yb_we;
   logic [MIW-1:0]          yb_waddr;
   logic                    w_we;
   logic [W_AW-1:0]         w_waddr;

   assign uw        = rdlc_pkg::UCODE_ROM[pc_ff];
   assign req_tready = uw.wait_start;
   assign req_acc   = req_tvalid && req_tready;
   assign start     = req_acc && (req_op == rdlc_pkg::OP_RUN);
   assign out_busy  = rsp_tvalid_ff && !rsp_tready;

   assign col_last  = (col_cnt_ff == CCW'(N_IN - 1));
   assign row_last  = (row_cnt_ff == RCW'(N_OUT - 1));
   assign mem_last  = (mem_cnt_ff == MIW'(N_MEM - 1));

   // next step of the control program
   always_comb begin
      hold = (uw.wait_start && !start) || (uw.wait_out && out_busy);
      case (uw.jc)
         rdlc_pkg::JC_NEXT:     jump = 1'b0;
         rdlc_pkg::JC_ALWAYS:   jump = 1'b1;
         rdlc_pkg::JC_COL_MORE: jump = !col_last;
         rdlc_pkg::JC_ROW_MORE: jump = !row_last;
         rdlc_pkg::JC_MEM_MORE: jump = !mem_last;
         default:               jump = 1'b0;
      endcase
      if (hold) begin
         pc_in = pc_ff;
      end else if (jump) begin
         pc_in = uw.target;
      end else begin
         pc_in = pc_ff + 3'd1;
      end
   end

   // counters, all cleared when a run starts
   always_comb begin
      row_cnt_in = row_cnt_ff;
      col_cnt_in = col_cnt_ff;
      mem_cnt_in = mem_cnt_ff;
      w_addr_in  = w_addr_ff;
      if (start) begin
         row_cnt_in = '0;
         col_cnt_in = '0;
         mem_cnt_in = '0;
         w_addr_in  = '0;
      end
      if (uw.issue) begin
         col_cnt_in = col_last ? '0 : col_cnt_ff + CCW'(1);
         w_addr_in  = w_addr_ff + W_AW'(1);
      end
      if (uw.row_end) begin
         row_cnt_in = row_cnt_ff + RCW'(1);
      end
      if (uw.mem_wr) begin
         mem_cnt_in = mem_cnt_ff + MIW'(1);
      end
   end

   // operand source for the column being issued
   always_comb begin
      col_maddr = MIW'(col_cnt_ff - CCW'(3));
      if (int'(col_cnt_ff) == 0) begin
         xs_in = rdlc_pkg::XS_SPEED;
      end else if (int'(col_cnt_ff) == 1) begin
         xs_in = rdlc_pkg::XS_ANGLE;
      end else if (int'(col_cnt_ff) == 2) begin
         xs_in = rdlc_pkg::XS_ONE;
      end else if (int'(col_cnt_ff) - 3 < N_MEM) begin
         xs_in = rdlc_pkg::XS_MEM;
      end else begin
         xs_in = rdlc_pkg::XS_ZERO;
      end
   end

   assign mem_raddr = uw.issue ? col_maddr : mem_cnt_ff;

   // x operand once the reads are back
   always_comb begin
      case (xs_ff)
         rdlc_pkg::XS_SPEED: x_val = 16'(spd_ff);
         rdlc_pkg::XS_ANGLE: x_val = 16'(ang_ff);
         rdlc_pkg::XS_ONE:   x_val = 16'(rdlc_pkg::Q_ONE);
         rdlc_pkg::XS_MEM:   x_val = mem_rvld_ff ? mem_rd_ff : '0;
         default:            x_val = '0;
      endcase
   end

   // floor shift back to 12 fraction bits and hard clamp to plus or minus one, as q1.12
   always_comb begin
      acc_sh = acc_ff >>> rdlc_pkg::FRAC_BITS;
      if (acc_sh > ACC_POS) begin
         y_clamp = Y_POS;
      end else if (acc_sh < ACC_NEG) begin
         y_clamp = Y_NEG;
      end else begin
         y_clamp = 14'(acc_sh);
      end
   end

   // row results for rows 2 through N_MEM+1 feed the memory update
   assign yb_we    = uw.row_end && (int'(row_cnt_ff) >= 2) && (int'(row_cnt_ff) - 2 < N_MEM);
   assign yb_waddr = MIW'(row_cnt_ff - RCW'(2));

   // leaky memory update, (7m + y) >> 3 with flooring
   always_comb begin
      m_cur   = mem_rvld_ff ? mem_rd_ff : '0;
      y_cur   = has_row_ff ? yb_rd_ff : '0;
      m20     = 20'(m_cur);
      upd_sum = (m20 <<< 3) - m20 + 20'(y_cur);
      m_new   = 16'(upd_sum >>> 3);
   end

   // memory write port, shared by the write transaction and the update sweep
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = mem_cnt_ff;
      mem_wdata = m_new;
      if (req_acc && (req_op == rdlc_pkg::OP_MEMORY) && (int'(req_col) < N_MEM)) begin
         mem_we    = 1'b1;
         mem_waddr = MIW'(req_col);
         mem_wdata = req_value;
      end else if (uw.mem_wr) begin
         mem_we = 1'b1;
      end
   end

   // weight write port
   assign w_we    = req_acc && (req_op == rdlc_pkg::OP_WEIGHT) &&
                    (int'(req_row) < N_OUT) && (int'(req_col) < N_IN);
   assign w_waddr = W_AW'(int'(req_row) * N_IN + int'(req_col));

   // acceleration reported times ten: 8y + 2y
   assign accel_val = (17'(y0_ff) <<< 3) + (17'(y0_ff) <<< 1);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff         <= rdlc_pkg::UP_IDLE;
         row_cnt_ff    <= '0;
         col_cnt_ff    <= '0;
         mem_cnt_ff    <= '0;
         w_addr_ff     <= '0;
         mem_vld_ff    <= '0;
         rd_vld_ff     <= 1'b0;
         prod_vld_ff   <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         pc_ff       <= pc_in;
         row_cnt_ff  <= row_cnt_in;
         col_cnt_ff  <= col_cnt_in;
         mem_cnt_ff  <= mem_cnt_in;
         w_addr_ff   <= w_addr_in;
         rd_vld_ff   <= uw.issue;
         prod_vld_ff <= rd_vld_ff;
         if (mem_we) begin
            mem_vld_ff[mem_waddr] <= 1'b1;
         end
         if (uw.out_load && !hold) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   // weight memory, registered read
   always_ff @(posedge clock) begin
      if (w_we) begin
         w_ram[w_waddr] <= req_value;
      end
      w_rd_ff <= w_ram[w_addr_ff];
   end

   // memory values, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ram[mem_waddr] <= mem_wdata;
      end
      mem_rd_ff   <= mem_ram[mem_raddr];
      mem_rvld_ff <= mem_vld_ff[mem_raddr];
   end

   // row result buffer for the memory update
   always_ff @(posedge clock) begin
      if (yb_we) begin
         yb_ram[yb_waddr] <= y_clamp;
      end
      yb_rd_ff   <= yb_ram[mem_cnt_ff];
      has_row_ff <= (int'(mem_cnt_ff) + 2 < N_OUT);
   end

   // multiply-accumulate and payload registers
   always_ff @(posedge clock) begin
      xs_ff   <= xs_in;
      prod_ff <= x_val * w_rd_ff;
      if (start) begin
         spd_ff <= req_speed;
         ang_ff <= req_angle;
      end
      if (uw.row_end) begin
         acc_ff <= '0;
      end else if (start) begin
         acc_ff <= '0;
      end else if (prod_vld_ff) begin
         acc_ff <= acc_ff + ACC_W'(prod_ff);
      end
      if (uw.row_end && (row_cnt_ff == RCW'(0))) begin
         y0_ff <= y_clamp;
      end
      if (uw.row_end && (row_cnt_ff == RCW'(1))) begin
         y1_ff <= y_clamp;
      end
      if (uw.out_load && !hold) begin
         rsp_accel_ff <= accel_val;
         rsp_turn_ff  <= y1_ff;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {1'b0, rsp_turn_ff, rsp_accel_ff};

endmodule

`default_nettype wire
